/* src/transport_frame_fragmenter_macros.svh */
// Assertion helpers shared by the checker.
`ifndef TRANSPORT_FRAME_FRAGMENTER_MACROS_SVH
`define TRANSPORT_FRAME_FRAGMENTER_MACROS_SVH

// Implication checked outside reset.
`define TFF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transport_frame_fragmenter: check failed");

// Next-cycle implication checked outside reset.
`define TFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transport_frame_fragmenter: check failed");

// Next-cycle implication that also holds across reset.
`define TFF_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("transport_frame_fragmenter: check failed");

`endif

/* src/tff_pkg.sv */
`default_nettype none
package tff_pkg;

  localparam int HEADER_LEN      = 5;
  localparam int FLAG_BYTE       = 4;
  localparam int HIDX_W          = $clog2(HEADER_LEN);
  localparam int HCNT_W          = $clog2(HEADER_LEN + 1);
  localparam int MAX_FRAME_LEN_D = 2048;
  localparam int LEN_IN_W        = 12;
  localparam int MP_W            = 12;
  localparam int MASK_W          = 8;
  localparam int CFG_DATA_W      = 12;
  localparam int CFG_IDX_W       = 1;
  // must stay a power of two, pointers wrap naturally
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MORE_FLAG_MASK = 1'd1;

  localparam logic [MP_W-1:0]   MAX_PAYLOAD_RST    = 12'd236;
  localparam logic [MASK_W-1:0] MORE_FLAG_MASK_RST = 8'd32;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_HDR,
    CMD_FRAG,
    CMD_FRAG_FIRST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic              fend;
    logic              more;
    logic [HIDX_W-1:0] hidx;
  } cmd_t;

  typedef struct packed {
    logic [MP_W-1:0]   max_payload;
    logic [MASK_W-1:0] more_mask;
  } cfg_t;

endpackage
`default_nettype wire

/* src/tff_front.sv */
`default_nettype none
module tff_front #(
  parameter int MAX_FRAME_LEN = tff_pkg::MAX_FRAME_LEN_D
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tff_pkg::cfg_t                 cfg,
  input  wire logic                          accept,
  input  wire logic [7:0]                    data_byte,
  input  wire logic [tff_pkg::LEN_IN_W-1:0]  frame_length,
  output tff_pkg::cmd_t                      cmd
);

  localparam int PW = $clog2(MAX_FRAME_LEN);
  localparam int LW = $clog2(MAX_FRAME_LEN + 1);
  localparam int CW = ((LW > tff_pkg::LEN_IN_W) ? LW : tff_pkg::LEN_IN_W) + 1;

  logic [PW-1:0]             pos_r, pos_nxt;
  logic [tff_pkg::MP_W-1:0]  chunk_r, chunk_nxt;
  logic                      frag_r, frag_nxt;

  logic [CW-1:0] fl_ext, len, mp, pos_ext, remaining, fill_inc;
  logic          last, frag_dec, frag, more, chunk_end, in_hdr;

  always_comb begin
    fl_ext  = CW'(frame_length);
    if (fl_ext == '0) begin
      len = CW'(1);
    end else if (fl_ext > CW'(MAX_FRAME_LEN)) begin
      len = CW'(MAX_FRAME_LEN);
    end else begin
      len = fl_ext;
    end
    mp        = (cfg.max_payload == '0) ? CW'(1) : CW'(cfg.max_payload);
    pos_ext   = CW'(pos_r);
    last      = (pos_ext + CW'(1)) >= len;
    frag_dec  = (len >= CW'(tff_pkg::HEADER_LEN)) &&
                ((len - CW'(tff_pkg::HEADER_LEN)) > mp);
    frag      = (pos_r == '0) ? frag_dec : frag_r;
    remaining = (len > pos_ext) ? (len - pos_ext) : CW'(1);
    more      = remaining > mp;
    fill_inc  = CW'(chunk_r) + CW'(1);
    chunk_end = last || (fill_inc >= mp);
    in_hdr    = pos_ext < CW'(tff_pkg::HEADER_LEN);

    cmd.data = data_byte;
    cmd.more = more;
    cmd.hidx = pos_r[tff_pkg::HIDX_W-1:0];
    if (!frag) begin
      cmd.kind = tff_pkg::CMD_PASS;
      cmd.fend = last;
    end else if (in_hdr) begin
      cmd.kind = tff_pkg::CMD_HDR;
      cmd.fend = 1'b0;
    end else begin
      cmd.kind = (chunk_r == '0) ? tff_pkg::CMD_FRAG_FIRST : tff_pkg::CMD_FRAG;
      cmd.fend = chunk_end;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    chunk_nxt = chunk_r;
    frag_nxt  = frag_r;
    if (accept) begin
      if (last) begin
        pos_nxt   = '0;
        chunk_nxt = '0;
        frag_nxt  = 1'b0;
      end else begin
        pos_nxt  = pos_r + PW'(1);
        frag_nxt = frag;
        if (frag && !in_hdr) begin
          chunk_nxt = chunk_end ? '0 : fill_inc[tff_pkg::MP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      chunk_r <= '0;
      frag_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      chunk_r <= chunk_nxt;
      frag_r  <= frag_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/tff_queue.sv */
`default_nettype none
module tff_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tff_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output tff_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);

  localparam int DEPTH = tff_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  tff_pkg::cmd_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNTW'(DEPTH));
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/tff_back.sv */
`default_nettype none
module tff_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tff_pkg::cfg_t cfg,
  input  wire tff_pkg::cmd_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_frame_end,
  output logic               out_run_last
);

  logic [7:0]                  hdr_r [tff_pkg::HEADER_LEN];
  logic                        hdr_we;
  logic [tff_pkg::HCNT_W-1:0]  hcnt_r, hcnt_nxt;
  logic                        valid_r, valid_nxt;
  logic [7:0]                  byte_r, byte_nxt;
  logic                        fend_r, fend_nxt, rl_r, rl_nxt;
  logic                        load_ok;
  logic [7:0]                  hdr_byte;

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_frame_end = fend_r;
  assign out_run_last  = rl_r;

  assign load_ok = !valid_r || out_ready;

  always_comb begin
    hdr_byte = hdr_r[hcnt_r[tff_pkg::HIDX_W-1:0]];
    if ((hcnt_r == tff_pkg::HCNT_W'(tff_pkg::FLAG_BYTE)) && head.more) begin
      hdr_byte = hdr_byte | cfg.more_mask;
    end
  end

  always_comb begin
    pop       = 1'b0;
    hdr_we    = 1'b0;
    hcnt_nxt  = hcnt_r;
    valid_nxt = valid_r && !out_ready;
    byte_nxt  = byte_r;
    fend_nxt  = fend_r;
    rl_nxt    = rl_r;
    if (!empty) begin
      unique case (head.kind) inside
        tff_pkg::CMD_HDR: begin
          // header byte is held back, no output word
          pop    = 1'b1;
          hdr_we = 1'b1;
        end
        tff_pkg::CMD_PASS, tff_pkg::CMD_FRAG: begin
          if (load_ok) begin
            pop       = 1'b1;
            valid_nxt = 1'b1;
            byte_nxt  = head.data;
            fend_nxt  = head.fend;
            rl_nxt    = 1'b1;
          end
        end
        tff_pkg::CMD_FRAG_FIRST: begin
          if (load_ok) begin
            valid_nxt = 1'b1;
            if (hcnt_r < tff_pkg::HCNT_W'(tff_pkg::HEADER_LEN)) begin
              byte_nxt = hdr_byte;
              fend_nxt = 1'b0;
              rl_nxt   = 1'b0;
              hcnt_nxt = hcnt_r + tff_pkg::HCNT_W'(1);
            end else begin
              pop      = 1'b1;
              byte_nxt = head.data;
              fend_nxt = head.fend;
              rl_nxt   = 1'b1;
              hcnt_nxt = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[head.hidx] <= head.data;
    end
    byte_r <= byte_nxt;
    fend_r <= fend_nxt;
    rl_r   <= rl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hcnt_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/transport_frame_fragmenter.sv */
// Transport frame fragmenter. Takes one frame byte per word, each with the
// frame's total length, and emits the frame unchanged, or, when its payload
// exceeds max_payload, as fragments that each start with a copy of the
// five-byte header (byte 4 ORed with more_flag_mask in all but the last).
// Input takes one word per cycle while the four-entry command queue has room.
// The output side emits one word per cycle while out_ready does not stall it;
// each held header byte is taken with no output; the first payload byte of each
// fragment goes out as five replayed header bytes, then the byte. The queue and
// output register absorb these bursts; the output side sets the sustained rate.
// The user must write registers through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`default_nettype none
module transport_frame_fragmenter #(
  parameter int MAX_FRAME_LEN = tff_pkg::MAX_FRAME_LEN_D
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [tff_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tff_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic [tff_pkg::LEN_IN_W-1:0]    in_frame_length,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 out_frame_end,
  output logic                                 out_run_last
);

  tff_pkg::cfg_t cfg_r, cfg_nxt;
  tff_pkg::cmd_t front_cmd, head;
  logic          accept, pop, q_empty, q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tff_pkg::CFG_MAX_PAYLOAD:    cfg_nxt.max_payload = cfg_data[tff_pkg::MP_W-1:0];
        tff_pkg::CFG_MORE_FLAG_MASK: cfg_nxt.more_mask   = cfg_data[tff_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload <= tff_pkg::MAX_PAYLOAD_RST;
      cfg_r.more_mask   <= tff_pkg::MORE_FLAG_MASK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  tff_front #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .frame_length (in_frame_length),
    .cmd          (front_cmd)
  );

  tff_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tff_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule
`default_nettype wire

/* src/tff_checker.sv */
`default_nettype none
`include "transport_frame_fragmenter_macros.svh"
module tff_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_frame_end,
  input wire logic       out_run_last
);

  // replayed header words never close a fragment
  `TFF_ASSERT_IMP(a_hdr_not_end, out_valid && !out_run_last, !out_frame_end)

  // a stalled word holds
  `TFF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_byte) && $stable(out_frame_end) &&
                   $stable(out_run_last))

  // nothing on the output right after reset
  `TFF_ASSERT_NEXT_RST(a_rst_quiet, !rst_n, !out_valid)

  // a header replay word is always followed by more words of the same run
  `TFF_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !out_run_last, out_valid)

  // an offered input word waits until taken
  `TFF_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)

endmodule

bind transport_frame_fragmenter tff_checker u_tff_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_frame_end (out_frame_end),
  .out_run_last  (out_run_last)
);
`default_nettype wire

/* sim/tb_transport_frame_fragmenter.sv */
module tb_transport_frame_fragmenter;

  typedef struct packed {
    logic [7:0] data;
    logic       fend;
    logic       run_last;
  } frag_word_t;

  typedef enum logic [1:0] {
    HINT_MODEL,
    HINT_NONE,
    HINT_ONE
  } row_hint_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [7:0]                   data;
    logic [tff_pkg::LEN_IN_W-1:0] len;
    row_hint_t                    hint;
    logic [7:0]                   exp_data;
    logic                         exp_fend;
  } dir_row_t;

  localparam int NUM_DIRECTED = 20;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_WORDS  = 28;
  localparam int SETTLE_CYCLES = 24;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [tff_pkg::CFG_IDX_W-1:0]  cfg_index = tff_pkg::CFG_MAX_PAYLOAD;
  logic [tff_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_data_byte = 8'h00;
  logic [tff_pkg::LEN_IN_W-1:0]   in_frame_length = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [7:0]                     out_byte;
  logic                           out_frame_end;
  logic                           out_run_last;

  // travels with the word so the checker knows how to build its expectation
  row_hint_t  row_hint = HINT_MODEL;
  logic [7:0] row_exp_data = 8'h00;
  logic       row_exp_fend = 1'b0;

  int send_gap_pct = 0;
  int stall_pct = 0;

  // predictor state
  logic [tff_pkg::MP_W-1:0]   model_max_payload = tff_pkg::MAX_PAYLOAD_RST;
  logic [tff_pkg::MASK_W-1:0] model_more_mask = tff_pkg::MORE_FLAG_MASK_RST;
  logic [7:0]                 model_header [tff_pkg::HEADER_LEN];
  int                         model_pos = 0;
  int                         model_fill = 0;
  logic                       model_splitting = 1'b0;

  frag_word_t step_out [$];
  frag_word_t expected_words [$];

  int mismatch_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int words_sent = 0;
  int settings_used = 1;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'h00, 12'd0,    HINT_ONE,   8'h00, 1'b1},  // zero length acts as one
    '{8'hFF, 12'd1,    HINT_ONE,   8'hFF, 1'b1},
    '{8'h10, 12'd3,    HINT_ONE,   8'h10, 1'b0},  // shorter than a header
    '{8'h20, 12'd3,    HINT_ONE,   8'h20, 1'b0},
    '{8'h30, 12'd3,    HINT_ONE,   8'h30, 1'b1},
    '{8'hA5, 12'hFFF,  HINT_NONE,  8'h00, 1'b0},  // saturated length, header held
    '{8'h11, 12'hFFF,  HINT_NONE,  8'h00, 1'b0},
    '{8'h22, 12'hFFF,  HINT_NONE,  8'h00, 1'b0},
    '{8'h33, 12'hFFF,  HINT_NONE,  8'h00, 1'b0},
    '{8'h44, 12'hFFF,  HINT_NONE,  8'h00, 1'b0},
    '{8'h5C, 12'hFFF,  HINT_MODEL, 8'h00, 1'b0},  // header replay with more flag
    '{8'hC3, 12'hFFF,  HINT_MODEL, 8'h00, 1'b0},
    '{8'h3D, 12'd8,    HINT_MODEL, 8'h00, 1'b0},  // length shrinks, frame ends here
    '{8'h7E, 12'd2048, HINT_NONE,  8'h00, 1'b0},
    '{8'h81, 12'd2,    HINT_NONE,  8'h00, 1'b0},  // ends inside held header
    '{8'h00, 12'd5,    HINT_MODEL, 8'h00, 1'b0},  // header-only frame
    '{8'h55, 12'd5,    HINT_MODEL, 8'h00, 1'b0},
    '{8'hAA, 12'd5,    HINT_MODEL, 8'h00, 1'b0},
    '{8'h0F, 12'd5,    HINT_MODEL, 8'h00, 1'b0},
    '{8'hF0, 12'd5,    HINT_MODEL, 8'h00, 1'b0}
  };

  transport_frame_fragmenter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_frame_length (in_frame_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end),
    .out_run_last    (out_run_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Computes the words one input byte produces, into step_out.
  task automatic fragment_step(input logic [7:0] b,
                               input logic [tff_pkg::LEN_IN_W-1:0] len_in);
    int len;
    int mp;
    int remaining;
    logic is_last;
    logic more;
    logic end_now;
    logic [7:0] h;
    step_out.delete();
    mp = (model_max_payload == 0) ? 1 : int'(model_max_payload);
    len = (len_in == 0) ? 1 : int'(len_in);
    if (len > tff_pkg::MAX_FRAME_LEN_D) len = tff_pkg::MAX_FRAME_LEN_D;
    is_last = (model_pos + 1 >= len);
    if (model_pos == 0) begin
      model_splitting = (len >= tff_pkg::HEADER_LEN) && (len - tff_pkg::HEADER_LEN > mp);
    end
    if (!model_splitting) begin
      step_out.push_back('{b, is_last, 1'b0});
    end else if (model_pos < tff_pkg::HEADER_LEN) begin
      model_header[model_pos] = b;
    end else begin
      if (model_fill == 0) begin
        remaining = (len > model_pos) ? len - model_pos : 1;
        more = (remaining > mp);
        for (int i = 0; i < tff_pkg::HEADER_LEN; i++) begin
          h = model_header[i];
          if (i == tff_pkg::FLAG_BYTE && more) h = h | model_more_mask;
          step_out.push_back('{h, 1'b0, 1'b0});
        end
      end
      model_fill++;
      end_now = is_last || (model_fill >= mp);
      step_out.push_back('{b, end_now, 1'b0});
      if (end_now) model_fill = 0;
    end
    if (is_last) begin
      model_pos = 0;
      model_fill = 0;
      model_splitting = 1'b0;
    end else begin
      model_pos++;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
  endtask

  always @(posedge clk) begin
    frag_word_t got;
    frag_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        fragment_step(in_data_byte, in_frame_length);
        case (row_hint)
          HINT_MODEL: begin
            foreach (step_out[i]) expected_words.push_back(step_out[i]);
          end
          HINT_ONE: begin
            expected_words.push_back('{row_exp_data, row_exp_fend, 1'b1});
          end
          default: ;
        endcase
        accepted_count++;
      end
      if (out_valid && out_ready) begin
        got = '{out_byte, out_frame_end, out_run_last};
        result_count++;
        if (expected_words.size() == 0) begin
          note_error($sformatf("unexpected word byte=%02h end=%0b run_last=%0b",
                               got.data, got.fend, got.run_last));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            note_error($sformatf({"word %0d: expected byte=%02h end=%0b run_last=%0b, ",
                                  "got byte=%02h end=%0b run_last=%0b"},
                                 result_count, want.data, want.fend, want.run_last,
                                 got.data, got.fend, got.run_last));
          end
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic [tff_pkg::LEN_IN_W-1:0] len,
                           input row_hint_t hint = HINT_MODEL,
                           input logic [7:0] eb = 8'h00, input logic ee = 1'b0);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_frame_length <= len;
    row_hint        <= hint;
    row_exp_data    <= eb;
    row_exp_fend    <= ee;
    words_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold input off until all expected words are out, then let header-only
  // work inside the block settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_words.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      note_error($sformatf("%0d expected words never arrived", expected_words.size()));
      expected_words.delete();
    end
  endtask

  task automatic set_config(input logic [tff_pkg::MP_W-1:0] mp,
                            input logic [tff_pkg::MASK_W-1:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= tff_pkg::CFG_MAX_PAYLOAD;
    cfg_data  <= tff_pkg::CFG_DATA_W'(mp);
    @(posedge clk);
    model_max_payload = mp;
    cfg_index <= tff_pkg::CFG_MORE_FLAG_MASK;
    cfg_data  <= tff_pkg::CFG_DATA_W'(mask);
    @(posedge clk);
    model_more_mask = mask;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One frame, mostly well formed; some are cut short by a length change
  // and then closed with a one-byte length.
  task automatic random_frame(input int cap);
    int pick;
    int flen;
    int k;
    pick = $urandom_range(0, 99);
    flen = $urandom_range(2, cap);
    if (pick < 5) begin
      send_word(8'($urandom_range(0, 255)), 12'd0);
    end else if (pick < 80) begin
      for (int i = 0; i < flen; i++) begin
        send_word(8'($urandom_range(0, 255)), 12'(flen));
      end
    end else begin
      k = $urandom_range(1, flen - 1);
      for (int i = 0; i < k; i++) begin
        send_word(8'($urandom_range(0, 255)), 12'(flen));
      end
      send_word(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
      send_word(8'($urandom_range(0, 255)), 12'd1);
    end
  endtask

  initial begin
    int mp_list [NUM_PHASES];
    int mask_list [NUM_PHASES];
    idle_mode_t idle_list [NUM_PHASES];
    int mp;
    int mp_eff;
    int cap;
    int start;
    mp_list   = '{0, 1, 3, 4095, 2048, 7, 2, 5, 0};
    mask_list = '{8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h80, 8'h01, 8'h20, 0, 0};
    idle_list = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
                  IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};
    for (int i = 0; i < tff_pkg::HEADER_LEN; i++) model_header[i] = 8'h00;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset register values
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].data, directed_rows[i].len, directed_rows[i].hint,
                directed_rows[i].exp_data, directed_rows[i].exp_fend);
    end
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      mp = mp_list[p];
      if (p == 7) mask_list[p] = $urandom_range(0, 255);
      if (p == NUM_PHASES - 1) begin
        mp = $urandom_range(1, 12);
        mask_list[p] = $urandom_range(0, 255);
      end
      set_config(tff_pkg::MP_W'(mp), tff_pkg::MASK_W'(mask_list[p]));
      case (idle_list[p])
        IDLE_NONE: begin send_gap_pct = 0;  stall_pct = 0;  end
        IDLE_SEND: begin send_gap_pct = 52; stall_pct = 0;  end
        IDLE_RECV: begin send_gap_pct = 0;  stall_pct = 52; end
        default:   begin send_gap_pct = 10; stall_pct = 10; end
      endcase
      mp_eff = (mp == 0) ? 1 : mp;
      cap = (mp_eff >= 8) ? 24 : 3 * mp_eff + 8;
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) random_frame(cap);
      drain_results();
    end

    $display("run covered %0d input words and %0d output words", accepted_count, result_count);
    $display("across %0d register settings and four idle/stall profiles", settings_used);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/tff_pkg.sv
src/tff_front.sv
src/tff_queue.sv
src/tff_back.sv
src/transport_frame_fragmenter.sv
src/tff_checker.sv
sim/tb_transport_frame_fragmenter.sv
